@@ sv/lmf_pkg.sv @@
// Shared constants and types for the line message filter.
`timescale 1ns / 1ps
`default_nettype none

package lmf_pkg;

  localparam int LMF_LINE_DEPTH = 64;
  // Widest line index for the largest supported line depth (256).
  localparam int LMF_MAX_IDX_W  = 8;
  localparam int LMF_CFG_IDX_W  = 2;
  localparam int LMF_BYTE_W     = 8;

  localparam logic [LMF_BYTE_W-1:0] LMF_RESET_REJECT = 8'h23;
  localparam logic [LMF_BYTE_W-1:0] LMF_RESET_END    = 8'h0A;

  localparam logic [LMF_CFG_IDX_W-1:0] LMF_CFG_REJECT = 2'd0;
  localparam logic [LMF_CFG_IDX_W-1:0] LMF_CFG_END    = 2'd1;

  // Store write from the front end: one byte into one of two line banks.
  typedef struct packed {
    logic                     en;
    logic                     bank;
    logic [LMF_MAX_IDX_W-1:0] idx;
    logic [LMF_BYTE_W-1:0]    data;
  } lmf_wr_t;

  // Replay command: bank holding the line, stored byte count, terminator.
  typedef struct packed {
    logic                     bank;
    logic [LMF_MAX_IDX_W-1:0] count;
    logic [LMF_BYTE_W-1:0]    term;
  } lmf_cmd_t;

  // Replay finished; bank is free again.
  typedef struct packed {
    logic valid;
    logic bank;
  } lmf_done_t;

endpackage

`default_nettype wire

@@ sv/line_message_filter.sv @@
// Line message filter top level: front end, command queue, back end.
`timescale 1ns / 1ps
`default_nettype none

// Frames received bytes into lines ended by end_char. Lines starting with, or
// containing, reject_char are dropped, as are lines longer than LINE_DEPTH-1
// stored bytes. The front end takes one byte per cycle while it is not
// stalled; a finished line is replayed from a two-bank store, each byte by a
// store read and then the output register, then the terminator and hand-over.
// Input stalls only while both banks hold lines waiting for replay.

module line_message_filter import lmf_pkg::*; #(
  parameter int LINE_DEPTH = LMF_LINE_DEPTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [LMF_CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LMF_BYTE_W-1:0]    cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [LMF_BYTE_W-1:0]    data_byte_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [LMF_BYTE_W-1:0]         out_byte_o,
  output logic                          out_last_o
);

  lmf_wr_t   wr;
  lmf_cmd_t  cmd_push, cmd_head;
  lmf_done_t done;
  logic      push, pop, cmd_valid;

  lmf_front #(.LINE_DEPTH(LINE_DEPTH)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .done_i      (done),
    .push_o      (push),
    .cmd_o       (cmd_push),
    .wr_o        (wr)
  );

  lmf_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_push),
    .pop_i   (pop),
    .valid_o (cmd_valid),
    .head_o  (cmd_head)
  );

  lmf_back #(.LINE_DEPTH(LINE_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_head),
    .pop_o       (pop),
    .done_o      (done),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

`default_nettype wire

@@ sv/lmf_front.sv @@
// Front end: register file, byte classification, line collection.
`timescale 1ns / 1ps
`default_nettype none

module lmf_front import lmf_pkg::*; #(
  parameter int LINE_DEPTH = LMF_LINE_DEPTH
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [LMF_CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [LMF_BYTE_W-1:0]    cfg_data_i,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [LMF_BYTE_W-1:0]    data_byte_i,
  input  wire lmf_done_t                done_i,
  output logic                          push_o,
  output lmf_cmd_t                      cmd_o,
  output lmf_wr_t                       wr_o
);

  localparam int CW = $clog2(LINE_DEPTH);
  localparam logic [CW-1:0] FullIdx = CW'(LINE_DEPTH - 1);

  localparam logic [1:0] ModeIdle    = 2'd0;
  localparam logic [1:0] ModeDrop    = 2'd1;
  localparam logic [1:0] ModeCollect = 2'd2;

  logic [LMF_BYTE_W-1:0] reject_q, end_q;
  logic [1:0]            mode_q, mode_d;
  logic [CW-1:0]         fill_q, fill_d;
  logic                  bank_q, bank_d;
  logic [1:0]            busy_q, busy_d;
  logic                  acc, is_rej, is_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_q <= LMF_RESET_REJECT;
      end_q    <= LMF_RESET_END;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        LMF_CFG_REJECT: reject_q <= cfg_data_i;
        LMF_CFG_END:    end_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A bank stays busy from its terminator until the back end has replayed it.
  assign in_ready_o = !busy_q[bank_q];
  assign acc        = in_valid_i && in_ready_o;
  assign is_rej     = data_byte_i == reject_q;
  assign is_end     = data_byte_i == end_q;

  always_comb begin
    mode_d  = mode_q;
    fill_d  = fill_q;
    bank_d  = bank_q;
    push_o  = 1'b0;
    wr_o.en = 1'b0;
    wr_o.bank = bank_q;
    wr_o.idx  = LMF_MAX_IDX_W'(fill_q);
    wr_o.data = data_byte_i;
    if (acc) begin
      case (mode_q)
        ModeDrop: begin
          if (is_end) mode_d = ModeIdle;
        end
        ModeCollect: begin
          if (is_rej) begin
            fill_d = '0;
            mode_d = is_end ? ModeIdle : ModeDrop;
          end else if (is_end) begin
            push_o = 1'b1;
            fill_d = '0;
            mode_d = ModeIdle;
            bank_d = !bank_q;
          end else if (fill_q >= FullIdx) begin
            // line too long for the store
            fill_d = '0;
            mode_d = ModeDrop;
          end else begin
            wr_o.en = 1'b1;
            fill_d  = fill_q + 1'b1;
          end
        end
        default: begin
          if (is_rej) begin
            mode_d = ModeDrop;
          end else if (is_end) begin
            mode_d = ModeIdle;
          end else begin
            wr_o.en  = 1'b1;
            wr_o.idx = '0;
            fill_d   = CW'(1);
            mode_d   = ModeCollect;
          end
        end
      endcase
    end
  end

  assign cmd_o.bank  = bank_q;
  assign cmd_o.count = LMF_MAX_IDX_W'(fill_q);
  assign cmd_o.term  = data_byte_i;

  always_comb begin
    busy_d = busy_q;
    if (done_i.valid) busy_d[done_i.bank] = 1'b0;
    if (push_o)       busy_d[bank_q]      = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      fill_q <= '0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      mode_q <= mode_d;
      fill_q <= fill_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/lmf_cmd_fifo.sv @@
// Two-entry queue of replay commands between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module lmf_cmd_fifo import lmf_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  input  wire lmf_cmd_t cmd_i,
  input  wire logic     pop_i,
  output logic          valid_o,
  output lmf_cmd_t      head_o
);

  lmf_cmd_t   entry_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;

  assign valid_o = count_q != 2'd0;
  assign head_o  = entry_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wptr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) wptr_q <= !wptr_q;
      if (pop_i)  rptr_q <= !rptr_q;
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

`default_nettype wire

@@ sv/lmf_back.sv @@
// Back end: two-bank line store and line replay to the output.
`timescale 1ns / 1ps
`default_nettype none

module lmf_back import lmf_pkg::*; #(
  parameter int LINE_DEPTH = LMF_LINE_DEPTH
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lmf_wr_t               wr_i,
  input  wire logic                  cmd_valid_i,
  input  wire lmf_cmd_t              cmd_i,
  output logic                       pop_o,
  output lmf_done_t                  done_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [LMF_BYTE_W-1:0]      out_byte_o,
  output logic                       out_last_o
);

  localparam int CW = $clog2(LINE_DEPTH);
  localparam int MemDepth = 2 << CW;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StOut  = 2'd2;
  localparam logic [1:0] StTerm = 2'd3;

  logic [LMF_BYTE_W-1:0] mem [MemDepth];
  logic [LMF_BYTE_W-1:0] byte_q;
  logic [1:0]            state_q, state_d;
  logic [CW-1:0]         idx_q, idx_d, idx_nx, count;
  logic                  load_term;

  assign count  = cmd_i.count[CW-1:0];
  assign idx_nx = idx_q + 1'b1;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) mem[{wr_i.bank, wr_i.idx[CW-1:0]}] <= wr_i.data;
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StRead) byte_q <= mem[{cmd_i.bank, idx_q}];
    else if (load_term)    byte_q <= cmd_i.term;
  end

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    load_term    = 1'b0;
    pop_o        = 1'b0;
    done_o.valid = 1'b0;
    done_o.bank  = cmd_i.bank;
    case (state_q)
      StIdle: begin
        if (cmd_valid_i) begin
          idx_d = '0;
          if (count == '0) begin
            load_term = 1'b1;
            state_d   = StTerm;
          end else begin
            state_d = StRead;
          end
        end
      end
      StRead: state_d = StOut;
      StOut: begin
        if (out_ready_i) begin
          idx_d = idx_nx;
          if (idx_nx == count) begin
            load_term = 1'b1;
            state_d   = StTerm;
          end else begin
            state_d = StRead;
          end
        end
      end
      StTerm: begin
        if (out_ready_i) begin
          pop_o        = 1'b1;
          done_o.valid = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign out_valid_o = (state_q == StOut) || (state_q == StTerm);
  assign out_last_o  = state_q == StTerm;
  assign out_byte_o  = byte_q;

endmodule

`default_nettype wire

@@ sv/lmf_checker.sv @@
// Port-level checks for the line message filter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lmf_checker import lmf_pkg::*; #(
  parameter int LINE_DEPTH = LMF_LINE_DEPTH
) (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     cfg_we_i,
  input wire logic [LMF_CFG_IDX_W-1:0] cfg_idx_i,
  input wire logic [LMF_BYTE_W-1:0]    cfg_data_i,
  input wire logic                     out_valid_o,
  input wire logic                     out_ready_i,
  input wire logic [LMF_BYTE_W-1:0]    out_byte_o,
  input wire logic                     out_last_o
);

  logic [LMF_BYTE_W-1:0] reject_q, end_q;
  logic [8:0]            run_q;
  logic                  xfer;

  assign xfer = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_q <= LMF_RESET_REJECT;
      end_q    <= LMF_RESET_END;
      run_q    <= '0;
    end else begin
      if (cfg_we_i && cfg_idx_i == LMF_CFG_REJECT) reject_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == LMF_CFG_END)    end_q    <= cfg_data_i;
      if (xfer) run_q <= out_last_o ? 9'd0 : run_q + 9'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o) && $stable(out_last_o))
    else $error("output changed while stalled");

  a_last_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_o |-> out_byte_o == end_q)
    else $error("line closed by a byte other than the terminator");

  a_body_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_last_o |-> out_byte_o != end_q && out_byte_o != reject_q)
    else $error("line body holds a terminator or reject byte");

  a_run_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xfer && !out_last_o |-> run_q < 9'(LINE_DEPTH - 1))
    else $error("line longer than the store");

endmodule

bind line_message_filter lmf_checker #(.LINE_DEPTH(LINE_DEPTH)) u_lmf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i),
  .cfg_data_i  (cfg_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_byte_o  (out_byte_o),
  .out_last_o  (out_last_o)
);

`default_nettype wire
